>>> rtl/pltg_pkg.sv
// Shared constants and elaboration-time table functions for pixel_luminance_to_glyph.
// Holds the register indexes, mode codes, reset ramp and luminance thresholds.
// No dependencies.
`default_nettype none

package pltg_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_MODE      = 3'd0;
  localparam logic [2:0] CFG_GAMMA_A   = 3'd1;
  localparam logic [2:0] CFG_GAMMA_B   = 3'd2;
  localparam logic [2:0] CFG_GAMMA_C   = 3'd3;
  localparam logic [2:0] CFG_GLYPHS_LO = 3'd4;
  localparam logic [2:0] CFG_GLYPHS_HI = 3'd5;

  // Threshold modes. The unused fourth code behaves as linear.
  localparam logic [1:0] MODE_LINEAR  = 2'd0;
  localparam logic [1:0] MODE_NATURAL = 2'd1;
  localparam logic [1:0] MODE_GAMMA   = 2'd2;

  // Reset ramp " .:-=+*#%@", level 0 in the lowest byte.
  localparam logic [63:0] GLYPHS_LO_RESET = 64'h232A_2B3D_2D3A_2E20;
  localparam logic [15:0] GLYPHS_HI_RESET = 16'h4025;

  localparam int unsigned NUM_THR = 9;

  typedef logic [15:0] lum_t;

  // Linear mode: Y reaches level k when 10*Y >= k*65536, that is Y >= ceil(k*65536/10).
  function automatic lum_t linear_thr(input int unsigned k);
    return lum_t'((k * 65536 + 9) / 10);
  endfunction

  // CIE L* mode: ceil(((10k+16)/116)^3 * 65536).
  function automatic lum_t natural_thr(input int unsigned k);
    logic [63:0] base;
    logic [63:0] num;
    base = 64'(10 * k + 16);
    num  = base * base * base * 64'd65536;
    return lum_t'((num + 64'd1560895) / 64'd1560896);
  endfunction

  // One entry of the sRGB linearization table, round(65536 * lin(code/255)) with
  // half-up rounding and saturation at 65535. The curve part is solved exactly by a
  // binary search on (2y-1)^5 * 269025^12 <= 2^85 * (1000*code + 14025)^12.
  function automatic lum_t lin_entry(input int unsigned code);
    logic [319:0] d12;
    logic [319:0] rhs;
    logic [319:0] lhs;
    int unsigned  lo;
    int unsigned  hi;
    int unsigned  mid;
    int unsigned  n;
    int unsigned  i;
    if (code <= 10) begin
      return lum_t'((2 * code * 6553600 + 329460) / 658920);
    end
    d12 = 320'd1;
    for (i = 0; i < 12; i++) begin
      d12 = d12 * 320'd269025;
    end
    n   = 1000 * code + 14025;
    rhs = 320'd1;
    for (i = 0; i < 12; i++) begin
      rhs = rhs * 320'(n);
    end
    rhs = rhs << 85;
    lo  = 0;
    hi  = 65536;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      lhs = d12;
      for (i = 0; i < 5; i++) begin
        lhs = lhs * 320'(2 * mid - 1);
      end
      if (lhs <= rhs) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    if (lo > 65535) begin
      return 16'hFFFF;
    end
    return lum_t'(lo);
  endfunction

endpackage

`default_nettype wire

>>> rtl/pixel_luminance_to_glyph.sv
// pixel_luminance_to_glyph: maps an sRGB pixel to a brightness level 0..9 and a ramp glyph.
// A pixel is taken in every cycle while the pipeline can move. It passes three register
// stages: one for the linearization table, one for the three luminance multipliers, and
// one for the sum, the nine threshold compares and the glyph select. Its result is
// presented from the third stage's output register and is held there while out_stall is high.
// Each stage holds its request independently, so bubbles close up under output stall and
// in_stall rises only when all three stages are full and the output is stalled.
// The configuration port is always ready; write it only while the pipeline is empty.
// Depends on pltg_pkg and pltg_lin_rom.
`default_nettype none

module pixel_luminance_to_glyph
  import pltg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Pixel input
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_red,
  input  wire logic [7:0]  in_green,
  input  wire logic [7:0]  in_blue,
  // Glyph output
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_glyph,
  output logic [3:0]       out_level,
  // Configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  // Configuration registers.
  logic [1:0]  mode_r;
  logic [47:0] gamma_a_r;
  logic [47:0] gamma_b_r;
  logic [47:0] gamma_c_r;
  logic [63:0] glyphs_lo_r;
  logic [15:0] glyphs_hi_r;

  // Pipeline registers.
  logic        v1_r;
  lum_t        red_lin_r;
  lum_t        green_lin_r;
  lum_t        blue_lin_r;
  logic        v2_r;
  logic [31:0] prod_red_r;
  logic [31:0] prod_green_r;
  logic [31:0] prod_blue_r;
  logic        out_valid_r;
  logic [7:0]  glyph_r;
  logic [3:0]  level_r;

  logic        adv_out;
  logic        free2;
  logic        free1;
  lum_t        red_lin;
  lum_t        green_lin;
  lum_t        blue_lin;
  logic [33:0] lum_sum;
  lum_t        lum;
  lum_t        thr [NUM_THR];
  logic [3:0]  level_nxt;
  logic [79:0] ramp;
  logic [7:0]  glyph_nxt;

  assign cfg_ready = 1'b1;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_LINEAR;
      gamma_a_r   <= '0;
      gamma_b_r   <= '0;
      gamma_c_r   <= '0;
      glyphs_lo_r <= GLYPHS_LO_RESET;
      glyphs_hi_r <= GLYPHS_HI_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODE:      mode_r      <= cfg_data[1:0];
        CFG_GAMMA_A:   gamma_a_r   <= cfg_data[47:0];
        CFG_GAMMA_B:   gamma_b_r   <= cfg_data[47:0];
        CFG_GAMMA_C:   gamma_c_r   <= cfg_data[47:0];
        CFG_GLYPHS_LO: glyphs_lo_r <= cfg_data;
        CFG_GLYPHS_HI: glyphs_hi_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Per-stage flow control: a stage may load when it is empty or is moving on.
  assign adv_out  = !out_valid_r || !out_stall;
  assign free2    = !v2_r || adv_out;
  assign free1    = !v1_r || free2;
  assign in_stall = !free1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (free1) begin
        v1_r <= in_valid;
      end
      if (free2) begin
        v2_r <= v1_r;
      end
      if (adv_out) begin
        out_valid_r <= v2_r;
      end
    end
  end

  // Stage 1: linearize each channel.
  pltg_lin_rom u_lin_rom (
    .red_code   (in_red),
    .green_code (in_green),
    .blue_code  (in_blue),
    .red_lin    (red_lin),
    .green_lin  (green_lin),
    .blue_lin   (blue_lin)
  );

  always_ff @(posedge clk) begin
    if (free1 && in_valid) begin
      red_lin_r   <= red_lin;
      green_lin_r <= green_lin;
      blue_lin_r  <= blue_lin;
    end
  end

  // Stage 2: weight each channel by its luminance coefficient.
  always_ff @(posedge clk) begin
    if (free2 && v1_r) begin
      prod_red_r   <= 32'(red_lin_r) * 32'd13933;
      prod_green_r <= 32'(green_lin_r) * 32'd46871;
      prod_blue_r  <= 32'(blue_lin_r) * 32'd4732;
    end
  end

  // Stage 3: luminance, threshold count and glyph select.
  assign lum_sum = 34'(prod_red_r) + 34'(prod_green_r) + 34'(prod_blue_r);
  assign lum     = lum_sum[31:16];

  always_comb begin
    for (int k = 0; k < NUM_THR; k++) begin
      case (mode_r)
        MODE_NATURAL: thr[k] = natural_thr(k + 1);
        MODE_GAMMA: begin
          if (k < 3) begin
            thr[k] = gamma_a_r[16 * (k % 3) +: 16];
          end else if (k < 6) begin
            thr[k] = gamma_b_r[16 * (k % 3) +: 16];
          end else begin
            thr[k] = gamma_c_r[16 * (k % 3) +: 16];
          end
        end
        default: thr[k] = linear_thr(k + 1);
      endcase
    end
  end

  always_comb begin
    level_nxt = '0;
    for (int k = 0; k < NUM_THR; k++) begin
      level_nxt = level_nxt + 4'(lum >= thr[k]);
    end
  end

  assign ramp      = {glyphs_hi_r, glyphs_lo_r};
  assign glyph_nxt = ramp[{level_nxt, 3'b000} +: 8];

  always_ff @(posedge clk) begin
    if (adv_out && v2_r) begin
      glyph_r <= glyph_nxt;
      level_r <= level_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_glyph = glyph_r;
  assign out_level = level_r;

endmodule

`default_nettype wire

>>> rtl/pltg_lin_rom.sv
// sRGB-to-linear lookup table with three read ports, one per color channel.
// Table contents are computed at elaboration by pltg_pkg::lin_entry.
`default_nettype none

module pltg_lin_rom
  import pltg_pkg::*;
(
  input  wire logic [7:0] red_code,
  input  wire logic [7:0] green_code,
  input  wire logic [7:0] blue_code,
  output lum_t            red_lin,
  output lum_t            green_lin,
  output lum_t            blue_lin
);

  lum_t lin_tab [256];

  // Constant table, one entry per sRGB code.
  for (genvar gi = 0; gi < 256; gi++) begin : g_tab
    localparam lum_t ENTRY = lin_entry(gi);
    assign lin_tab[gi] = ENTRY;
  end

  assign red_lin   = lin_tab[red_code];
  assign green_lin = lin_tab[green_code];
  assign blue_lin  = lin_tab[blue_code];

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for pixel_luminance_to_glyph: random and directed pixels,
// with an in-bench predictor of the sRGB linearization, luminance and ramp lookup.
// Depends on pltg_pkg and the pixel_luminance_to_glyph RTL.
`timescale 1ns / 1ps

module testbench;
  import pltg_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] glyph;
    logic [3:0] level;
  } glyph_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_red = 8'd0;
  logic [7:0]  in_green = 8'd0;
  logic [7:0]  in_blue = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_glyph;
  logic [3:0]  out_level;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = CFG_MODE;
  logic [63:0] cfg_data = 64'd0;

  // Predictor copy of the configuration registers.
  logic [1:0]  cur_mode = MODE_LINEAR;
  logic [47:0] gam_a = 48'd0;
  logic [47:0] gam_b = 48'd0;
  logic [47:0] gam_c = 48'd0;
  logic [63:0] ramp_lo = GLYPHS_LO_RESET;
  logic [15:0] ramp_hi = GLYPHS_HI_RESET;

  lum_t        lin_table [256];
  lum_t        cie_bound [1:9];

  pixel_t      pixels_pending [$];
  glyph_res_t  glyphs_due [$];

  int unsigned px_accepted = 0;
  int unsigned px_handled = 0;
  int unsigned px_gap = 0;
  int unsigned res_accepted = 0;
  int unsigned res_handled = 0;
  int unsigned rx_wait = 0;
  int unsigned rx_hold = 0;
  int unsigned err_cnt = 0;
  logic        no_idle = 1'b0;
  logic        burst = 1'b0;
  logic        long_hold_req = 1'b0;
  logic        long_hold_done = 1'b0;

  pixel_luminance_to_glyph DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_glyph (out_glyph),
    .out_level (out_level),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Linear value of one sRGB code in Q0.16. The curve segment finds the largest y with
  // (2y-1)^5 * 269025^12 <= 2^85 * (1000*code + 14025)^12, one bit at a time.
  function automatic lum_t srgb_to_linear(input int unsigned code);
    logic [319:0] den12;
    logic [319:0] num12;
    logic [319:0] lhs;
    int unsigned  base;
    int unsigned  y;
    int unsigned  cand;
    int unsigned  j;
    int           bitn;
    if (code <= 10) begin
      return lum_t'((2 * code * 6553600 + 329460) / 658920);
    end
    den12 = 320'd1;
    num12 = 320'd1;
    base  = 1000 * code + 14025;
    for (j = 0; j < 12; j++) begin
      den12 = den12 * 320'd269025;
      num12 = num12 * 320'(base);
    end
    num12 = num12 << 85;
    y = 0;
    for (bitn = 16; bitn >= 0; bitn--) begin
      cand = y | (32'd1 << bitn);
      lhs  = den12;
      for (j = 0; j < 5; j++) begin
        lhs = lhs * 320'(2 * cand - 1);
      end
      if (lhs <= num12) begin
        y = cand;
      end
    end
    return (y > 65535) ? 16'hFFFF : lum_t'(y);
  endfunction

  // CIE L* level boundary, rounded up.
  function automatic lum_t cie_bound_of(input int unsigned k);
    logic [63:0] lstar;
    logic [63:0] num;
    logic [63:0] q;
    lstar = 64'(10 * k + 16);
    num   = lstar * lstar * lstar * 64'd65536;
    q     = num / 64'd1560896;
    if (q * 64'd1560896 != num) begin
      q = q + 64'd1;
    end
    return lum_t'(q);
  endfunction

  // Expected glyph and level for one pixel under the current register copy.
  function automatic glyph_res_t pixel_to_glyph(input pixel_t px);
    logic [47:0] acc;
    lum_t        y;
    lum_t        thr;
    logic [47:0] src;
    logic [79:0] ramp;
    logic        hit;
    int unsigned k;
    glyph_res_t  res;
    acc = 48'd13933 * lin_table[px.red] + 48'd46871 * lin_table[px.green]
        + 48'd4732 * lin_table[px.blue];
    y = acc[31:16];
    res.level = 4'd0;
    for (k = 1; k <= 9; k++) begin
      case (cur_mode)
        MODE_NATURAL: hit = (y >= cie_bound[k]);
        MODE_GAMMA: begin
          src = (k <= 3) ? gam_a : (k <= 6) ? gam_b : gam_c;
          thr = src[16 * ((k - 1) % 3) +: 16];
          hit = (y >= thr);
        end
        default: hit = (64'(y) * 64'd10 >= 64'(k) * 64'd65536);
      endcase
      if (hit) begin
        res.level = res.level + 4'd1;
      end
    end
    ramp = {ramp_hi, ramp_lo};
    res.glyph = ramp[8 * res.level +: 8];
    return res;
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t      px;
    int unsigned sel;
    logic [7:0]  v;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      px = {8'($urandom), 8'($urandom), 8'($urandom)};
    end else if (sel < 8) begin
      // Gray pixels sweep the levels.
      v  = 8'($urandom);
      px = {v, v, v};
    end else begin
      px = {8'($urandom_range(0, 40)), 8'($urandom_range(0, 40)), 8'($urandom_range(0, 40))};
    end
    return px;
  endfunction

  task automatic queue_px(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    pixels_pending.push_back({r, g, b});
  endtask

  task automatic queue_random(input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) begin
      pixels_pending.push_back(rand_pixel());
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Wait until every pending pixel has been taken and every result has come back.
  task automatic drain();
    while (pixels_pending.size() != 0 || in_valid || glyphs_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // Random ascending gamma thresholds, packed three per register, lowest level first.
  task automatic load_sorted_gamma();
    logic [15:0] t [1:9];
    int unsigned acc;
    int unsigned k;
    acc = 0;
    for (k = 1; k <= 9; k++) begin
      acc  = acc + $urandom_range(0, 7281);
      t[k] = acc[15:0];
    end
    write_reg(CFG_GAMMA_A, {16'($urandom), t[3], t[2], t[1]});
    write_reg(CFG_GAMMA_B, {16'($urandom), t[6], t[5], t[4]});
    write_reg(CFG_GAMMA_C, {16'($urandom), t[9], t[8], t[7]});
  endtask

  // Register writes, pixel requests and results are all sampled here, at the rising edge.
  always @(posedge clk) begin : monitor_blk
    glyph_res_t due;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MODE:      cur_mode = cfg_data[1:0];
          CFG_GAMMA_A:   gam_a = cfg_data[47:0];
          CFG_GAMMA_B:   gam_b = cfg_data[47:0];
          CFG_GAMMA_C:   gam_c = cfg_data[47:0];
          CFG_GLYPHS_LO: ramp_lo = cfg_data;
          CFG_GLYPHS_HI: ramp_hi = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        glyphs_due.push_back(pixel_to_glyph(pixels_pending[0]));
        pixels_pending.pop_front();
        px_accepted++;
      end
      if (out_valid && !out_stall) begin
        res_accepted++;
        if (glyphs_due.size() == 0) begin
          $error("unexpected result: glyph %0d level %0d", out_glyph, out_level);
          err_cnt++;
        end else begin
          due = glyphs_due.pop_front();
          if (out_glyph !== due.glyph) begin
            $error("glyph mismatch: expected %0d, actual %0d", due.glyph, out_glyph);
            err_cnt++;
          end
          if (out_level !== due.level) begin
            $error("level mismatch: expected %0d, actual %0d", due.level, out_level);
            err_cnt++;
          end
        end
      end
    end
  end

  // Pixel driver: holds each request until taken, then waits a random gap, none in no_idle or burst runs.
  always @(negedge clk) begin : driver_blk
    logic nxt_valid;
    if (rst_n) begin
      nxt_valid = in_valid;
      if (in_valid && px_accepted != px_handled) begin
        px_handled = px_accepted;
        nxt_valid  = 1'b0;
        px_gap     = (no_idle || burst) ? 0 : $urandom_range(0, 4);
      end
      if (!nxt_valid) begin
        if (px_gap > 0) begin
          px_gap--;
        end else if (pixels_pending.size() != 0) begin
          nxt_valid = 1'b1;
          in_red   <= pixels_pending[0].red;
          in_green <= pixels_pending[0].green;
          in_blue  <= pixels_pending[0].blue;
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // Result receiver: a random stall after each result unless no_idle is set, and one long hold-off on request.
  always @(negedge clk) begin
    if (rst_n) begin
      if (res_accepted != res_handled) begin
        res_handled = res_accepted;
        rx_wait     = no_idle ? 0 : $urandom_range(0, 4);
      end
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        rx_hold        = 120;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_stall <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus: phases separated by idle points where the registers change.
  initial begin : stim_blk
    int unsigned c;
    int unsigned k;
    for (c = 0; c < 256; c++) begin
      lin_table[c] = srgb_to_linear(c);
    end
    for (k = 1; k <= 9; k++) begin
      cie_bound[k] = cie_bound_of(k);
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: linear mode, default ramp. Extremes and the segment boundary.
    queue_px(8'd0, 8'd0, 8'd0);
    queue_px(8'd255, 8'd255, 8'd255);
    queue_px(8'd255, 8'd0, 8'd0);
    queue_px(8'd0, 8'd255, 8'd0);
    queue_px(8'd0, 8'd0, 8'd255);
    queue_px(8'd10, 8'd10, 8'd10);
    queue_px(8'd11, 8'd11, 8'd11);
    queue_px(8'd128, 8'd128, 8'd128);
    queue_random(200);
    drain();

    // CIE L* thresholds with a random ramp.
    write_reg(CFG_MODE, {62'd0, MODE_NATURAL});
    write_reg(CFG_GLYPHS_LO, {$urandom, $urandom});
    write_reg(CFG_GLYPHS_HI, {$urandom, $urandom});
    queue_px(8'd0, 8'd0, 8'd0);
    queue_px(8'd255, 8'd255, 8'd255);
    queue_px(8'd118, 8'd118, 8'd118);
    queue_random(200);
    drain();

    // Ascending gamma thresholds; upper register bits carry junk.
    load_sorted_gamma();
    write_reg(CFG_MODE, {62'd0, MODE_GAMMA});
    queue_random(200);
    drain();

    // Unordered gamma thresholds, both sides without idling.
    write_reg(CFG_GAMMA_A, {$urandom, $urandom});
    write_reg(CFG_GAMMA_B, {$urandom, $urandom});
    write_reg(CFG_GAMMA_C, {$urandom, $urandom});
    no_idle = 1'b1;
    queue_random(200);
    drain();
    no_idle = 1'b0;

    // All gamma thresholds zero: every pixel is brightest. All-ones ramp.
    write_reg(CFG_GAMMA_A, 64'd0);
    write_reg(CFG_GAMMA_B, 64'd0);
    write_reg(CFG_GAMMA_C, 64'd0);
    write_reg(CFG_GLYPHS_LO, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_GLYPHS_HI, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_px(8'd0, 8'd0, 8'd0);
    queue_px(8'd255, 8'd255, 8'd255);
    queue_random(20);
    drain();

    // All gamma thresholds at maximum: only full white gets past them. Zero ramp.
    write_reg(CFG_GAMMA_A, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_GAMMA_B, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_GAMMA_C, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_GLYPHS_LO, 64'd0);
    write_reg(CFG_GLYPHS_HI, 64'd0);
    queue_px(8'd255, 8'd255, 8'd255);
    queue_px(8'd254, 8'd255, 8'd255);
    queue_px(8'd255, 8'd255, 8'd254);
    queue_random(20);
    drain();

    // Unused mode code, written with all bits set; writes past the register list.
    write_reg(CFG_MODE, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(3'd6, {$urandom, $urandom});
    write_reg(3'd7, {$urandom, $urandom});
    write_reg(CFG_GLYPHS_LO, {$urandom, $urandom});
    write_reg(CFG_GLYPHS_HI, {$urandom, $urandom});
    queue_random(200);
    drain();

    // Back-to-back requests against a long receiver hold-off, so the pipeline fills.
    write_reg(CFG_MODE, {62'd0, MODE_LINEAR});
    write_reg(CFG_GLYPHS_LO, GLYPHS_LO_RESET);
    write_reg(CFG_GLYPHS_HI, {48'd0, GLYPHS_HI_RESET});
    burst = 1'b1;
    long_hold_req = 1'b1;
    queue_random(250);
    drain();
    burst = 1'b0;

    // Long random run in CIE L* mode, then in gamma mode with fresh thresholds.
    write_reg(CFG_MODE, {62'd0, MODE_NATURAL});
    queue_random(250);
    drain();
    load_sorted_gamma();
    write_reg(CFG_MODE, {62'd0, MODE_GAMMA});
    queue_random(200);
    drain();

    repeat (8) @(posedge clk);
    if (glyphs_due.size() != 0) begin
      $error("%0d expected results never arrived", glyphs_due.size());
    end
    if (err_cnt == 0 && glyphs_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> sim.f
rtl/pltg_pkg.sv
rtl/pltg_lin_rom.sv
rtl/pixel_luminance_to_glyph.sv
tb/testbench.sv
